>>> sv/ckt_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and a helper function for the caption key triplet parser.
// Depends on nothing; every other file imports it.
package ckt_pkg;

    localparam int PositionBits = 32;

    typedef logic [PositionBits-1:0] t_pos;

    localparam t_pos KeyStep = t_pos'(65536);

    localparam logic [7:0] HdrKeyStart = 8'hFF;
    localparam logic [7:0] HdrKeyCont  = 8'hFE;
    localparam logic [7:0] ChrC        = 8'h43;
    localparam logic [7:0] ChrQ        = 8'h51;
    localparam logic [7:0] ChrColon    = 8'h3A;
    localparam logic [7:0] ChrZero     = 8'h30;
    localparam logic [7:0] ChrNine     = 8'h39;
    localparam logic [7:0] ChrUpperA   = 8'h41;
    localparam logic [7:0] ChrUpperF   = 8'h46;
    localparam logic [7:0] PadByte     = 8'h80;
    localparam logic [1:0] FullCount   = 2'd3;
    localparam int         HdrValidBit = 2;
    localparam logic [3:0] HexTen      = 4'd10;

    typedef enum logic [1:0] {
        KP_IDLE,
        KP_GOT_CC,
        KP_GOT_QC,
        KP_GOT_HIGH
    } t_key_phase;

    typedef struct packed {
        logic [7:0]  header_byte;
        logic [7:0]  first_data_byte;
        logic [7:0]  second_data_byte;
        logic [1:0]  byte_count;
        logic        frame_last;
        logic [31:0] range_first;
        logic [31:0] range_end;
    } t_item;

    typedef struct packed {
        logic        has_position;
        logic [31:0] queue_position;
        logic        frame_end;
        logic        corrupted;
    } t_result;

    typedef struct packed {
        logic item_valid;
        logic out_free;
    } t_flow;

    typedef struct packed {
        logic ok;
        logic [3:0] value;
    } t_hex;

    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex h;
        h.ok = 1'b0;
        h.value = 4'd0;
        if (c >= ChrZero && c <= ChrNine) begin
            h.ok = 1'b1;
            h.value = 4'(c - ChrZero);
        end else if (c >= ChrUpperA && c <= ChrUpperF) begin
            h.ok = 1'b1;
            h.value = 4'(c - ChrUpperA) + HexTen;
        end
        return h;
    endfunction

endpackage

>>> sv/caption_key_triplet_parser.sv
`timescale 1ns / 1ps
// Caption key triplet parser: one triplet word per cycle; an accepted word passes to its
// result through an input register, the key logic and a result register.
// A word that causes no result leaves no trace at the output side.
// Throughput is one word per cycle while the output is not stalled.
// Synchronous active-low reset clears the key state, the sticky flag and both valids.
module caption_key_triplet_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_header_byte,
    input  logic [7:0]  i_first_data_byte,
    input  logic [7:0]  i_second_data_byte,
    input  logic [1:0]  i_byte_count,
    input  logic        i_frame_last,
    input  logic [31:0] i_range_first,
    input  logic [31:0] i_range_end,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_has_position,
    output logic [31:0] o_queue_position,
    output logic        o_frame_end,
    output logic        o_corrupted
);
    import ckt_pkg::*;

    t_item   in_item, stage_item;
    t_result step_result, out_result;
    t_flow   flow;
    logic    stage_valid, advance, emit, out_free;

    assign in_item.header_byte = i_header_byte;
    assign in_item.first_data_byte = i_first_data_byte;
    assign in_item.second_data_byte = i_second_data_byte;
    assign in_item.byte_count = i_byte_count;
    assign in_item.frame_last = i_frame_last;
    assign in_item.range_first = i_range_first;
    assign in_item.range_end = i_range_end;

    ckt_in_stage u_in_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_item       (in_item),
        .i_advance    (advance),
        .o_stall      (o_stall),
        .o_item_valid (stage_valid),
        .o_item       (stage_item)
    );

    assign flow.item_valid = stage_valid;
    assign flow.out_free = out_free;

    ckt_key_fsm u_key_fsm (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_flow    (flow),
        .i_item    (stage_item),
        .o_advance (advance),
        .o_emit    (emit),
        .o_result  (step_result)
    );

    ckt_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (emit && advance),
        .i_result (step_result),
        .i_stall  (i_stall),
        .o_free   (out_free),
        .o_valid  (o_valid),
        .o_result (out_result)
    );

    assign o_has_position = out_result.has_position;
    assign o_queue_position = out_result.queue_position;
    assign o_frame_end = out_result.frame_end;
    assign o_corrupted = out_result.corrupted;

endmodule

>>> sv/ckt_in_stage.sv
`timescale 1ns / 1ps
// Input register of the parser: holds one triplet word until the key logic takes it.
// Depends on ckt_pkg.
module ckt_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  ckt_pkg::t_item i_item,
    input  logic           i_advance,
    output logic           o_stall,
    output logic           o_item_valid,
    output ckt_pkg::t_item o_item
);
    import ckt_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  can_load;

    assign can_load = !r_valid || i_advance;
    assign o_stall = !can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (can_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (can_load && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_item_valid = r_valid;
    assign o_item = r_item;

endmodule

>>> sv/ckt_key_fsm.sv
`timescale 1ns / 1ps
// Key recogniser: padding skip, key template match, hex decode, position recovery
// and the corruption and discard state. Depends on ckt_pkg.
module ckt_key_fsm (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ckt_pkg::t_flow   i_flow,
    input  ckt_pkg::t_item   i_item,
    output logic             o_advance,
    output logic             o_emit,
    output ckt_pkg::t_result o_result
);
    import ckt_pkg::*;

    t_key_phase  r_phase, n_phase;
    logic [15:0] r_digits, n_digits;
    logic        r_discard, n_discard;
    logic        r_sticky, n_sticky;

    t_hex        hex1, hex2;
    t_pos        lo_bound, hi_bound, cand_val, cand_lo, cand_hi, found_pos;
    logic        in_lo, in_mid, in_hi, found, corrupt, pad, emit;

    assign hex1 = hex_decode(i_item.first_data_byte);
    assign hex2 = hex_decode(i_item.second_data_byte);
    assign lo_bound = t_pos'(i_item.range_first);
    assign hi_bound = t_pos'(i_item.range_end);
    assign cand_val = {hi_bound[PositionBits-1:16], r_digits[15:8], hex1.value, hex2.value};
    assign cand_lo = cand_val - KeyStep;
    assign cand_hi = cand_val + KeyStep;
    assign in_lo = (cand_lo >= lo_bound) && (cand_lo < hi_bound);
    assign in_mid = (cand_val >= lo_bound) && (cand_val < hi_bound);
    assign in_hi = (cand_hi >= lo_bound) && (cand_hi < hi_bound);

    always_comb begin
        found_pos = '0;
        priority if (in_lo) begin
            found_pos = cand_lo;
        end else if (in_mid) begin
            found_pos = cand_val;
        end else if (in_hi) begin
            found_pos = cand_hi;
        end
    end

    assign pad = (i_item.header_byte[1:0] <= 2'd1)
        ? (i_item.first_data_byte == PadByte && i_item.second_data_byte == PadByte)
        : !i_item.header_byte[HdrValidBit];

    always_comb begin
        n_phase = r_phase;
        n_digits = r_digits;
        n_discard = r_discard;
        n_sticky = r_sticky;
        corrupt = 1'b0;
        found = 1'b0;
        if (!r_discard) begin
            if (i_item.byte_count != FullCount) begin
                corrupt = 1'b1;
            end else begin
                unique case (r_phase)
                    KP_IDLE: begin
                        if (!pad) begin
                            if (i_item.header_byte == HdrKeyStart
                                    && i_item.first_data_byte == ChrC
                                    && i_item.second_data_byte == ChrC) begin
                                n_phase = KP_GOT_CC;
                            end else begin
                                corrupt = 1'b1;
                            end
                        end
                    end
                    KP_GOT_CC: begin
                        if (i_item.header_byte == HdrKeyCont
                                && i_item.first_data_byte == ChrQ
                                && i_item.second_data_byte == ChrColon) begin
                            n_phase = KP_GOT_QC;
                        end else begin
                            corrupt = 1'b1;
                        end
                    end
                    KP_GOT_QC: begin
                        if (i_item.header_byte != HdrKeyCont || !hex1.ok || !hex2.ok) begin
                            corrupt = 1'b1;
                        end else begin
                            n_digits = {hex1.value, hex2.value, 8'h00};
                            n_phase = KP_GOT_HIGH;
                        end
                    end
                    KP_GOT_HIGH: begin
                        if (i_item.header_byte != HdrKeyCont || !hex1.ok || !hex2.ok) begin
                            corrupt = 1'b1;
                        end else begin
                            found = in_lo || in_mid || in_hi;
                            n_phase = KP_IDLE;
                            n_digits = 16'd0;
                            corrupt = !found;
                        end
                    end
                    default: begin
                        corrupt = 1'b1;
                    end
                endcase
            end
        end
        if (corrupt) begin
            n_sticky = 1'b1;
            n_discard = 1'b1;
            n_phase = KP_IDLE;
            n_digits = 16'd0;
        end
        if (i_item.frame_last) begin
            if (!n_discard && n_phase != KP_IDLE) begin
                n_sticky = 1'b1;
            end
            n_phase = KP_IDLE;
            n_digits = 16'd0;
            n_discard = 1'b0;
        end
    end

    assign emit = found || i_item.frame_last;
    assign o_emit = i_flow.item_valid && emit;
    assign o_advance = i_flow.item_valid && (!emit || i_flow.out_free);

    assign o_result.has_position = found;
    assign o_result.queue_position = found ? 32'(found_pos) : 32'd0;
    assign o_result.frame_end = i_item.frame_last;
    assign o_result.corrupted = n_sticky;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= KP_IDLE;
            r_digits <= 16'd0;
            r_discard <= 1'b0;
            r_sticky <= 1'b0;
        end else if (o_advance) begin
            r_phase <= n_phase;
            r_digits <= n_digits;
            r_discard <= n_discard;
            r_sticky <= n_sticky;
        end
    end

endmodule

>>> sv/ckt_out_stage.sv
`timescale 1ns / 1ps
// Result register of the parser: holds one result word until downstream takes it.
// Depends on ckt_pkg.
module ckt_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  ckt_pkg::t_result i_result,
    input  logic             i_stall,
    output logic             o_free,
    output logic             o_valid,
    output ckt_pkg::t_result o_result
);
    import ckt_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid = r_valid;
    assign o_result = r_result;

endmodule
